/* rtl/t2pwm_pkg.sv */
// Package of constants and types for the thrust to PWM converter core.
package t2pwm_pkg;

    typedef enum logic [1:0] {
        OP_FORCE = 2'd0,
        OP_SPEED = 2'd1,
        OP_MASS  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_OFFSET = 2'd0,
        REG_SLOPE  = 2'd1,
        REG_KCONST = 2'd2,
        REG_NONE   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        SPD_ZERO  = 2'd0,
        SPD_VALUE = 2'd1,
        SPD_ROOT  = 2'd2
    } speed_sel_t;

    typedef struct packed {
        speed_sel_t sel;
        logic       force_zero;
    } ctl_t;

    localparam int DEFAULT_VALUE_BITS = 24;
    localparam int CFG_W      = 32;
    localparam int SPEED_W    = 24;
    localparam int KCONST_W   = 32;
    localparam logic [KCONST_W-1:0] KCONST_RESET = 32'd42949673;
    localparam int G_NUM      = 981;
    localparam int G_DEN      = 400;
    localparam int GSCALE_W   = 9;
    localparam int DEN_W      = KCONST_W + GSCALE_W;
    localparam int QUO_W      = 64;
    localparam int FRAC_BITS  = 48;
    localparam int SAT_SHIFT  = QUO_W - FRAC_BITS;
    localparam int DIV_PER    = 2;
    localparam int DIV_ST     = QUO_W / DIV_PER;
    localparam int ROOT_W     = QUO_W / 2;
    localparam int SQ_REM_W   = ROOT_W + 2;
    localparam int SQ_PER     = 2;
    localparam int SQ_ST      = ROOT_W / SQ_PER;
    localparam int D_W        = ROOT_W + 2;
    localparam int PWM_W      = 8;
    localparam int PW_PER     = 2;
    localparam int PW_ST      = PWM_W / PW_PER;

endpackage

/* rtl/thrust_to_pwm_converter_core.sv */
// Top level of the thrust to PWM converter: a fully pipelined force, speed or mass to PWM path.
//
// Channel | Signals                            | Direction
// input   | in_valid, in_ready, opcode, value  | item in
// output  | out_valid, out_ready, pwm, flag    | item out
// config  | cfg_write, cfg_index, cfg_data     | write only
//
// One item enters per cycle while the output is not stalled.
// Most of the pipeline depth is in the 64-bit scaled divider (32 stages) and the square root (16 stages).
// Reset clears all valid bits and loads the register reset values.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module thrust_to_pwm_converter_core #(
    parameter int VALUE_BITS = t2pwm_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           opcode,
    input  logic signed [VALUE_BITS-1:0]         command_value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [t2pwm_pkg::PWM_W-1:0]          pwm_duty,
    output logic                                 slope_zero,
    input  logic                                 cfg_write,
    input  logic [1:0]                           cfg_index,
    input  logic [t2pwm_pkg::CFG_W-1:0]          cfg_data
);

    localparam int NUM_W  = VALUE_BITS + t2pwm_pkg::GSCALE_W;
    localparam int DEN_W  = t2pwm_pkg::DEN_W;
    localparam int QUO_W  = t2pwm_pkg::QUO_W;
    localparam int ROOT_W = t2pwm_pkg::ROOT_W;
    localparam int REM_W  = t2pwm_pkg::SQ_REM_W;
    localparam int D_W    = t2pwm_pkg::D_W;
    localparam int SP_W   = t2pwm_pkg::SPEED_W;
    localparam int PWM_W  = t2pwm_pkg::PWM_W;
    localparam int DIV_ST = t2pwm_pkg::DIV_ST;
    localparam int SQ_ST  = t2pwm_pkg::SQ_ST;
    localparam int PW_ST  = t2pwm_pkg::PW_ST;
    localparam int SAT_SH = t2pwm_pkg::SAT_SHIFT;
    localparam int FRAC   = t2pwm_pkg::FRAC_BITS;
    localparam int KW     = t2pwm_pkg::KCONST_W;

    logic signed [SP_W-1:0] offset_reg;
    logic signed [SP_W-1:0] slope_reg;
    logic [KW-1:0]          kconst_reg;

    logic adv;

    // Multiply stage.
    logic                         mu_vld_reg;
    t2pwm_pkg::ctl_t              mu_ctl_reg;
    logic [NUM_W-1:0]             mu_num_reg;
    logic [DEN_W-1:0]             mu_den_reg;
    logic signed [VALUE_BITS-1:0] mu_v_reg;
    t2pwm_pkg::ctl_t              mu_ctl_next;
    logic [NUM_W-1:0]             mu_num_next;
    logic [DEN_W-1:0]             mu_den_next;

    // Divider stages.
    logic                         dv_vld_reg [0:DIV_ST];
    t2pwm_pkg::ctl_t              dv_ctl_reg [0:DIV_ST];
    logic [DEN_W-1:0]             dv_r_reg   [0:DIV_ST];
    logic [QUO_W-1:0]             dv_w_reg   [0:DIV_ST];
    logic [DEN_W-1:0]             dv_den_reg [0:DIV_ST];
    logic                         dv_sat_reg [0:DIV_ST];
    logic signed [VALUE_BITS-1:0] dv_v_reg   [0:DIV_ST];
    logic                         dv_sat_next;

    // Square root stages.
    logic                         sq_vld_reg  [0:SQ_ST];
    t2pwm_pkg::ctl_t              sq_ctl_reg  [0:SQ_ST];
    logic [QUO_W-1:0]             sq_x_reg    [0:SQ_ST];
    logic [REM_W-1:0]             sq_rem_reg  [0:SQ_ST];
    logic [ROOT_W-1:0]            sq_root_reg [0:SQ_ST];
    logic signed [VALUE_BITS-1:0] sq_v_reg    [0:SQ_ST];

    // Speed difference stage.
    logic                  dd_vld_reg;
    logic                  dd_force_reg;
    logic signed [D_W-1:0] dd_d_reg;
    logic signed [D_W-1:0] dd_d_next;
    logic signed [D_W-1:0] speed_ext;

    // PWM quotient stages.
    logic              pw_vld_reg  [0:PW_ST];
    logic              pw_zero_reg [0:PW_ST];
    logic              pw_big_reg  [0:PW_ST];
    logic [SP_W-1:0]   pw_r_reg    [0:PW_ST];
    logic [PWM_W-1:0]  pw_w_reg    [0:PW_ST];
    logic [D_W-1:0]    d_abs;
    logic [SP_W-1:0]   s_abs;
    logic              pw_zero_next;
    logic              pw_big_next;

    logic              out_valid_reg;
    logic [PWM_W-1:0]  pwm_reg;
    logic              sz_reg;
    logic [PWM_W-1:0]  pwm_next;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign pwm_duty  = pwm_reg;
    assign slope_zero = sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            slope_reg  <= '0;
            kconst_reg <= t2pwm_pkg::KCONST_RESET;
        end
        else if (cfg_write)
        begin
            unique case (t2pwm_pkg::reg_index_t'(cfg_index))
                t2pwm_pkg::REG_OFFSET: offset_reg <= cfg_data[SP_W-1:0];
                t2pwm_pkg::REG_SLOPE:  slope_reg  <= cfg_data[SP_W-1:0];
                t2pwm_pkg::REG_KCONST: kconst_reg <= cfg_data[KW-1:0];
                t2pwm_pkg::REG_NONE:   ;
            endcase
        end
    end

    always_comb
    begin
        logic             pos;
        logic [VALUE_BITS-1:0] v_u;
        logic [NUM_W-1:0] prod;
        logic [DEN_W-1:0] kden;
        logic             is_mass;
        pos = !command_value[VALUE_BITS-1] && (command_value != '0);
        v_u = command_value;
        prod = {{(NUM_W-VALUE_BITS){1'b0}}, v_u} * NUM_W'(t2pwm_pkg::G_NUM);
        kden = {{(DEN_W-KW){1'b0}}, kconst_reg} * DEN_W'(t2pwm_pkg::G_DEN);
        is_mass = 1'b0;
        mu_ctl_next.force_zero = 1'b0;
        mu_ctl_next.sel = t2pwm_pkg::SPD_ZERO;
        unique case (t2pwm_pkg::opcode_t'(opcode))
            t2pwm_pkg::OP_FORCE: mu_ctl_next.sel = pos ? t2pwm_pkg::SPD_ROOT : t2pwm_pkg::SPD_ZERO;
            t2pwm_pkg::OP_SPEED: mu_ctl_next.sel = t2pwm_pkg::SPD_VALUE;
            t2pwm_pkg::OP_MASS:
            begin
                mu_ctl_next.sel = pos ? t2pwm_pkg::SPD_ROOT : t2pwm_pkg::SPD_ZERO;
                is_mass = 1'b1;
            end
            t2pwm_pkg::OP_NONE:  mu_ctl_next.force_zero = 1'b1;
        endcase
        mu_num_next = is_mass ? prod : {{(NUM_W-VALUE_BITS){1'b0}}, v_u};
        mu_den_next = is_mass ? kden : {{(DEN_W-KW){1'b0}}, kconst_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mu_vld_reg <= 1'b0;
        else if (adv)
            mu_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mu_ctl_reg <= mu_ctl_next;
            mu_num_reg <= mu_num_next;
            mu_den_reg <= mu_den_next;
            mu_v_reg   <= command_value;
        end
    end

    // The quotient overflows 64 bits exactly when num reaches den * 2^16.
    assign dv_sat_next = (mu_den_reg == '0) ||
        ({{(DEN_W+SAT_SH-NUM_W){1'b0}}, mu_num_reg} >= {mu_den_reg, {SAT_SH{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= mu_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_ctl_reg[0] <= mu_ctl_reg;
            dv_r_reg[0]   <= {{(DEN_W-NUM_W+SAT_SH){1'b0}}, mu_num_reg[NUM_W-1:SAT_SH]};
            dv_w_reg[0]   <= {mu_num_reg[SAT_SH-1:0], {FRAC{1'b0}}};
            dv_den_reg[0] <= mu_den_reg;
            dv_sat_reg[0] <= dv_sat_next;
            dv_v_reg[0]   <= mu_v_reg;
        end
    end

    for (genvar g = 0; g < DIV_ST; g++)
    begin : g_div
        logic [DEN_W-1:0] r_next;
        logic [QUO_W-1:0] w_next;

        always_comb
        begin
            logic [DEN_W-1:0] r;
            logic [DEN_W:0]   r2;
            logic [QUO_W-1:0] w;
            logic             ge;
            r = dv_r_reg[g];
            w = dv_w_reg[g];
            for (int j = 0; j < t2pwm_pkg::DIV_PER; j++)
            begin
                r2 = {r, w[QUO_W-1]};
                ge = r2 >= {1'b0, dv_den_reg[g]};
                w  = {w[QUO_W-2:0], ge};
                r  = ge ? DEN_W'(r2 - {1'b0, dv_den_reg[g]}) : r2[DEN_W-1:0];
            end
            r_next = r;
            w_next = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[g+1] <= 1'b0;
            else if (adv)
                dv_vld_reg[g+1] <= dv_vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctl_reg[g+1] <= dv_ctl_reg[g];
                dv_r_reg[g+1]   <= r_next;
                dv_w_reg[g+1]   <= w_next;
                dv_den_reg[g+1] <= dv_den_reg[g];
                dv_sat_reg[g+1] <= dv_sat_reg[g];
                dv_v_reg[g+1]   <= dv_v_reg[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= dv_vld_reg[DIV_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_ctl_reg[0]  <= dv_ctl_reg[DIV_ST];
            sq_x_reg[0]    <= dv_sat_reg[DIV_ST] ? '1 : dv_w_reg[DIV_ST];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_v_reg[0]    <= dv_v_reg[DIV_ST];
        end
    end

    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_sqrt
        logic [QUO_W-1:0]  x_next;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            logic [QUO_W-1:0]  x;
            logic [REM_W-1:0]  rem;
            logic [REM_W+1:0]  rem2;
            logic [REM_W+1:0]  trial;
            logic [ROOT_W-1:0] root;
            logic              ge;
            x    = sq_x_reg[g];
            rem  = sq_rem_reg[g];
            root = sq_root_reg[g];
            for (int j = 0; j < t2pwm_pkg::SQ_PER; j++)
            begin
                rem2  = {rem, x[QUO_W-1:QUO_W-2]};
                trial = {{(REM_W-ROOT_W){1'b0}}, root, 2'b01};
                ge    = rem2 >= trial;
                rem   = ge ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
                root  = {root[ROOT_W-2:0], ge};
                x     = {x[QUO_W-3:0], 2'b00};
            end
            x_next    = x;
            rem_next  = rem;
            root_next = root;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[g+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[g+1] <= sq_vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_ctl_reg[g+1]  <= sq_ctl_reg[g];
                sq_x_reg[g+1]    <= x_next;
                sq_rem_reg[g+1]  <= rem_next;
                sq_root_reg[g+1] <= root_next;
                sq_v_reg[g+1]    <= sq_v_reg[g];
            end
        end
    end

    always_comb
    begin
        unique case (sq_ctl_reg[SQ_ST].sel)
            t2pwm_pkg::SPD_VALUE:
                speed_ext = {{(D_W-VALUE_BITS){sq_v_reg[SQ_ST][VALUE_BITS-1]}},
                             sq_v_reg[SQ_ST]};
            t2pwm_pkg::SPD_ROOT:
                speed_ext = {{(D_W-ROOT_W){1'b0}}, sq_root_reg[SQ_ST]};
            default:
                speed_ext = '0;
        endcase
        dd_d_next = speed_ext - {{(D_W-SP_W){offset_reg[SP_W-1]}}, offset_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dd_vld_reg <= 1'b0;
        else if (adv)
            dd_vld_reg <= sq_vld_reg[SQ_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dd_force_reg <= sq_ctl_reg[SQ_ST].force_zero;
            dd_d_reg     <= dd_d_next;
        end
    end

    // Opposite signs give a quotient at or below zero, which clamps to zero.
    assign d_abs = dd_d_reg[D_W-1] ? D_W'(-dd_d_reg) : D_W'(dd_d_reg);
    assign s_abs = slope_reg[SP_W-1] ? SP_W'(-slope_reg) : SP_W'(slope_reg);
    assign pw_zero_next = dd_force_reg || (slope_reg == '0) ||
                          (dd_d_reg[D_W-1] != slope_reg[SP_W-1]);
    assign pw_big_next  = d_abs >= {{(D_W-SP_W-PWM_W){1'b0}}, s_abs, {PWM_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pw_vld_reg[0] <= 1'b0;
        else if (adv)
            pw_vld_reg[0] <= dd_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pw_zero_reg[0] <= pw_zero_next;
            pw_big_reg[0]  <= pw_big_next;
            pw_r_reg[0]    <= d_abs[SP_W+PWM_W-1:PWM_W];
            pw_w_reg[0]    <= d_abs[PWM_W-1:0];
        end
    end

    for (genvar g = 0; g < PW_ST; g++)
    begin : g_pwm
        logic [SP_W-1:0]  r_next;
        logic [PWM_W-1:0] w_next;

        always_comb
        begin
            logic [SP_W-1:0]  r;
            logic [SP_W:0]    r2;
            logic [PWM_W-1:0] w;
            logic             ge;
            r = pw_r_reg[g];
            w = pw_w_reg[g];
            for (int j = 0; j < t2pwm_pkg::PW_PER; j++)
            begin
                r2 = {r, w[PWM_W-1]};
                ge = r2 >= {1'b0, s_abs};
                w  = {w[PWM_W-2:0], ge};
                r  = ge ? SP_W'(r2 - {1'b0, s_abs}) : r2[SP_W-1:0];
            end
            r_next = r;
            w_next = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_vld_reg[g+1] <= 1'b0;
            else if (adv)
                pw_vld_reg[g+1] <= pw_vld_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pw_zero_reg[g+1] <= pw_zero_reg[g];
                pw_big_reg[g+1]  <= pw_big_reg[g];
                pw_r_reg[g+1]    <= r_next;
                pw_w_reg[g+1]    <= w_next;
            end
        end
    end

    always_comb
    begin
        priority if (pw_zero_reg[PW_ST])
            pwm_next = '0;
        else if (pw_big_reg[PW_ST])
            pwm_next = '1;
        else
            pwm_next = pw_w_reg[PW_ST];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= pw_vld_reg[PW_ST];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pwm_reg <= pwm_next;
            sz_reg  <= (slope_reg == '0);
        end
    end

`ifndef NO_ASSERTIONS
    a_slope_zero_pwm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slope_zero) |-> (pwm_duty == '0))
        else $error("pwm_duty is not zero while slope_zero is set");

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stage");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(pwm_duty) && $stable(slope_zero)))
        else $error("a stalled result item changed");

    a_unused_index: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == t2pwm_pkg::REG_NONE)) |=>
        ($stable(offset_reg) && $stable(slope_reg) && $stable(kconst_reg)))
        else $error("a write to an unused index changed a register");
`endif

endmodule
